@@ rtl/tae_pkg.sv @@
// Shared types, constants and abbreviation table of the token abbreviation expander.
package tae_pkg;

    localparam int TOKEN_BUFFER_BYTES_DEF = 64;
    localparam int OUTPUT_CAPACITY_DEF    = 4096;
    localparam int ENTRY_COUNT            = 52;
    localparam int EW                     = $clog2(ENTRY_COUNT);
    localparam int KEY_MAX                = 7;
    localparam int TEXT_MAX               = 41;
    localparam int KEY_BITS               = 8 * KEY_MAX;
    localparam int TEXT_BITS              = 8 * TEXT_MAX;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef logic [EW-1:0] entry_idx_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [TEXT_BITS-1:0] text;
    } rom_entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tae_mem_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MRD,
        S_MCMP,
        S_DECIDE,
        S_ERD,
        S_EOUT,
        S_TAIL
    } tae_state_t;

    // strings are right-aligned, zero padded on the left
    function automatic rom_entry_t rom_entry(input entry_idx_t idx);
        rom_entry_t r;
        unique case (idx)
            6'd0:  r = '{KEY_BITS'("Dr."),     TEXT_BITS'("Doctor")};
            6'd1:  r = '{KEY_BITS'("Mr."),     TEXT_BITS'("Mister")};
            6'd2:  r = '{KEY_BITS'("Mrs."),    TEXT_BITS'("Missus")};
            6'd3:  r = '{KEY_BITS'("Ms."),     TEXT_BITS'("Miss")};
            6'd4:  r = '{KEY_BITS'("Prof."),   TEXT_BITS'("Professor")};
            6'd5:  r = '{KEY_BITS'("Sr."),     TEXT_BITS'("Senior")};
            6'd6:  r = '{KEY_BITS'("Jr."),     TEXT_BITS'("Junior")};
            6'd7:  r = '{KEY_BITS'("i.e."),    TEXT_BITS'("that is")};
            6'd8:  r = '{KEY_BITS'("e.g."),    TEXT_BITS'("for example")};
            6'd9:  r = '{KEY_BITS'("etc."),    TEXT_BITS'("and so on")};
            6'd10: r = '{KEY_BITS'("vs."),     TEXT_BITS'("versus")};
            6'd11: r = '{KEY_BITS'("viz."),    TEXT_BITS'("namely")};
            6'd12: r = '{KEY_BITS'("cf."),     TEXT_BITS'("compare")};
            6'd13: r = '{KEY_BITS'("ibid."),   TEXT_BITS'("in the same place")};
            6'd14: r = '{KEY_BITS'("approx."), TEXT_BITS'("approximately")};
            6'd15: r = '{KEY_BITS'("incl."),   TEXT_BITS'("including")};
            6'd16: r = '{KEY_BITS'("excl."),   TEXT_BITS'("excluding")};
            6'd17: r = '{KEY_BITS'("max."),    TEXT_BITS'("maximum")};
            6'd18: r = '{KEY_BITS'("min."),    TEXT_BITS'("minimum")};
            6'd19: r = '{KEY_BITS'("avg."),    TEXT_BITS'("average")};
            6'd20: r = '{KEY_BITS'("est."),    TEXT_BITS'("estimated")};
            6'd21: r = '{KEY_BITS'("dept."),   TEXT_BITS'("department")};
            6'd22: r = '{KEY_BITS'("govt."),   TEXT_BITS'("government")};
            6'd23: r = '{KEY_BITS'("govts."),  TEXT_BITS'("governments")};
            6'd24: r = '{KEY_BITS'("org."),    TEXT_BITS'("organisation")};
            6'd25: r = '{KEY_BITS'("corp."),   TEXT_BITS'("corporation")};
            6'd26: r = '{KEY_BITS'("intl."),   TEXT_BITS'("international")};
            6'd27: r = '{KEY_BITS'("natl."),   TEXT_BITS'("national")};
            6'd28: r = '{KEY_BITS'("no."),     TEXT_BITS'("number")};
            6'd29: r = '{KEY_BITS'("fig."),    TEXT_BITS'("figure")};
            6'd30: r = '{KEY_BITS'("sec."),    TEXT_BITS'("section")};
            6'd31: r = '{KEY_BITS'("vol."),    TEXT_BITS'("volume")};
            6'd32: r = '{KEY_BITS'("yr."),     TEXT_BITS'("year")};
            6'd33: r = '{KEY_BITS'("yrs."),    TEXT_BITS'("years")};
            6'd34: r = '{KEY_BITS'("km."),     TEXT_BITS'("kilometres")};
            6'd35: r = '{KEY_BITS'("km"),      TEXT_BITS'("kilometres")};
            6'd36: r = '{KEY_BITS'("mph"),     TEXT_BITS'("miles per hour")};
            6'd37: r = '{KEY_BITS'("kph"),     TEXT_BITS'("kilometres per hour")};
            6'd38: r = '{KEY_BITS'("pct."),    TEXT_BITS'("percent")};
            6'd39: r = '{KEY_BITS'("pct"),     TEXT_BITS'("percent")};
            6'd40: r = '{KEY_BITS'("CO2"),     TEXT_BITS'("carbon dioxide")};
            6'd41: r = '{KEY_BITS'("CH4"),     TEXT_BITS'("methane")};
            6'd42: r = '{KEY_BITS'("GHG"),     TEXT_BITS'("greenhouse gas")};
            6'd43: r = '{KEY_BITS'("GHGs"),    TEXT_BITS'("greenhouse gases")};
            6'd44: r = '{KEY_BITS'("IPCC"),
                         TEXT_BITS'("Intergovernmental Panel on Climate Change")};
            6'd45: r = '{KEY_BITS'("EV"),      TEXT_BITS'("electric vehicle")};
            6'd46: r = '{KEY_BITS'("EVs"),     TEXT_BITS'("electric vehicles")};
            6'd47: r = '{KEY_BITS'("ICE"),     TEXT_BITS'("internal combustion engine")};
            6'd48: r = '{KEY_BITS'("kWh"),     TEXT_BITS'("kilowatt-hours")};
            6'd49: r = '{KEY_BITS'("MW"),      TEXT_BITS'("megawatts")};
            6'd50: r = '{KEY_BITS'("GW"),      TEXT_BITS'("gigawatts")};
            6'd51: r = '{KEY_BITS'("PV"),      TEXT_BITS'("photovoltaic")};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] key_len(input entry_idx_t idx);
        logic [KEY_BITS-1:0] k;
        logic [2:0]          n;
        k = rom_entry(idx).key;
        n = '0;
        for (int i = 0; i < KEY_MAX; i++)
            if (k[8*i +: 8] != 8'd0)
                n = 3'(i + 1);
        return n;
    endfunction

    function automatic logic [5:0] text_len(input entry_idx_t idx);
        logic [TEXT_BITS-1:0] t;
        logic [5:0]           n;
        t = rom_entry(idx).text;
        n = '0;
        for (int i = 0; i < TEXT_MAX; i++)
            if (t[8*i +: 8] != 8'd0)
                n = 6'(i + 1);
        return n;
    endfunction

    function automatic logic [7:0] key_char(input entry_idx_t idx, input logic [2:0] pos);
        logic [KEY_BITS-1:0] k;
        logic [2:0]          n;
        logic [7:0]          c;
        k = rom_entry(idx).key;
        n = key_len(idx);
        c = '0;
        if (pos < n)
            c = k[8*(int'(n) - 1 - int'(pos)) +: 8];
        return c;
    endfunction

    function automatic logic [7:0] text_char(input entry_idx_t idx, input logic [5:0] pos);
        logic [TEXT_BITS-1:0] t;
        logic [5:0]           n;
        logic [7:0]           c;
        t = rom_entry(idx).text;
        n = text_len(idx);
        c = '0;
        if (pos < n)
            c = t[8*(int'(n) - 1 - int'(pos)) +: 8];
        return c;
    endfunction

    function automatic logic is_capital(input logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    // keys of capitals only compare exactly
    function automatic logic key_exact(input entry_idx_t idx);
        logic [2:0] n;
        logic       e;
        n = key_len(idx);
        e = 1'b1;
        for (int i = 0; i < KEY_MAX; i++)
            if ((3'(i) < n) && !is_capital(key_char(idx, 3'(i))))
                e = 1'b0;
        return e;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return is_capital(c) ? (c + CASE_DELTA) : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

@@ rtl/tae_in_if.sv @@
// Input channel: one text byte or the end mark per item.
interface tae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ rtl/tae_out_if.sv @@
// Output channel: one character or status item per handshake.
interface tae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       done_res;
    logic       status;

    modport source (output valid, output out_byte, output has_byte, output last_of_run,
                    output done_res, output status, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input last_of_run,
                    input done_res, input status, output ready);
endinterface

@@ rtl/tae_token_mem.sv @@
// Token byte store: one write port, one read port with registered data.
module tae_token_mem #(
    parameter int DEPTH = tae_pkg::TOKEN_BUFFER_BYTES_DEF - 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  tae_pkg::tae_mem_ctl_t ctl,
    input  logic [AW-1:0]         wr_addr,
    input  logic [7:0]            wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [7:0]            rd_data
);
    import tae_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

@@ rtl/token_abbreviation_expander_unit.sv @@
// Top level of the token abbreviation expander.
//
// text_ch carries one byte per item, or the end mark (end_of_text = 1).
// Non-whitespace bytes go into the token store in one cycle each, with no
// result. Whitespace or the end mark (only the end mark after an overflow)
// flushes the token: a match pass reads the stored bytes (a read and a
// compare state per byte, only for tokens of up to 7 bytes) against all 52
// keys at once, then a decide state, then the expansion or the token goes
// out, a read state and an output state per byte, then the whitespace byte
// or the status item; the store's single read port sets the pace.
// result_ch is driven from an output register; a stalled receiver holds the
// sequencer in place, nothing is dropped. last_of_run marks the final item
// an input causes; the status item (done_res = 1) follows every end mark
// and reports 1 on output capacity overflow. The token store needs no
// clearing: only bytes written for the current token are read.
// Reset clears token length, output count, overflow flag and the output
// valid flag; text_ch is ready as soon as reset is released.
module token_abbreviation_expander_unit #(
    parameter int TOKEN_BUFFER_BYTES = tae_pkg::TOKEN_BUFFER_BYTES_DEF,
    parameter int OUTPUT_CAPACITY    = tae_pkg::OUTPUT_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tae_in_if.sink      text_ch,
    tae_out_if.source   result_ch
);
    import tae_pkg::*;

    localparam int KEEP = TOKEN_BUFFER_BYTES - 1;
    localparam int AW   = $clog2(KEEP);
    localparam int LW   = $clog2(TOKEN_BUFFER_BYTES);
    localparam int PW   = (LW > 6) ? LW : 6;
    localparam int CW   = $clog2(OUTPUT_CAPACITY);
    localparam int SW   = ((CW > PW) ? CW : PW) + 1;
    localparam logic [SW-1:0] LIMIT_S = SW'(OUTPUT_CAPACITY - 1);
    localparam logic [CW-1:0] LIMIT_C = CW'(OUTPUT_CAPACITY - 1);

    tae_state_t state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] n_reg, n_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    byte_reg, byte_next;
    logic          end_reg, end_next;
    logic          hit_reg, hit_next;
    entry_idx_t    entry_reg, entry_next;
    logic [ENTRY_COUNT-1:0] vec_reg, vec_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_has_reg, out_has_next;
    logic       out_last_reg, out_last_next;
    logic       out_done_reg, out_done_next;
    logic       out_status_reg, out_status_next;

    tae_mem_ctl_t  mem_ctl;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic          accept;
    logic          out_free;
    logic          dec_hit;
    entry_idx_t    dec_sel;
    logic [PW-1:0] dec_n;
    logic [SW-1:0] dec_sum;
    logic [7:0]    kc;
    logic          cmatch;

    tae_token_mem #(.DEPTH(KEEP), .AW(AW)) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (text_ch.text_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign text_ch.ready = (state_reg == S_IDLE);
    assign accept        = text_ch.valid && text_ch.ready;
    assign out_free      = !out_valid_reg || result_ch.ready;

    // first match wins
    always_comb
    begin
        dec_sel = '0;
        for (int e = ENTRY_COUNT - 1; e >= 0; e--)
            if (vec_reg[e])
                dec_sel = entry_idx_t'(e);
        dec_hit = |vec_reg;
        dec_n   = dec_hit ? PW'(text_len(dec_sel)) : PW'(len_reg);
        dec_sum = SW'(count_reg) + SW'(dec_n);
    end

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        byte_next       = byte_reg;
        end_next        = end_reg;
        hit_next        = hit_reg;
        entry_next      = entry_reg;
        vec_next        = vec_reg;
        out_valid_next  = out_valid_reg && !result_ch.ready;
        out_byte_next   = out_byte_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        out_status_next = out_status_reg;
        mem_ctl         = '0;
        wr_addr         = len_reg[AW-1:0];
        rd_addr         = pos_reg[AW-1:0];
        kc              = '0;
        cmatch          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    byte_next = text_ch.text_byte;
                    end_next  = text_ch.end_of_text;
                    pos_next  = '0;
                    for (int e = 0; e < ENTRY_COUNT; e++)
                        vec_next[e] = (PW'(key_len(entry_idx_t'(e))) == PW'(len_reg));
                    if (text_ch.end_of_text || (!ovf_reg && is_space(text_ch.text_byte)))
                    begin
                        if (ovf_reg || (len_reg == '0))
                        begin
                            len_next   = '0;
                            state_next = S_TAIL;
                        end
                        else if (PW'(len_reg) <= PW'(KEY_MAX))
                            state_next = S_MRD;
                        else
                            state_next = S_DECIDE;
                    end
                    else if (!ovf_reg && (len_reg < LW'(KEEP)))
                    begin
                        mem_ctl.wr_en = 1'b1;
                        len_next      = len_reg + LW'(1);
                    end
                end
            end

            S_MRD:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = S_MCMP;
            end

            S_MCMP:
            begin
                for (int e = 0; e < ENTRY_COUNT; e++)
                begin
                    kc     = key_char(entry_idx_t'(e), pos_reg[2:0]);
                    cmatch = key_exact(entry_idx_t'(e)) ? (rd_data == kc)
                                                        : (fold(rd_data) == fold(kc));
                    if (!cmatch)
                        vec_next[e] = 1'b0;
                end
                pos_next   = pos_reg + PW'(1);
                state_next = (pos_reg + PW'(1) == PW'(len_reg)) ? S_DECIDE : S_MRD;
            end

            S_DECIDE:
            begin
                hit_next   = dec_hit;
                entry_next = dec_sel;
                n_next     = dec_n;
                pos_next   = '0;
                if (dec_sum >= LIMIT_S)
                begin
                    ovf_next   = 1'b1;
                    len_next   = '0;
                    state_next = S_TAIL;
                end
                else
                    state_next = S_ERD;
            end

            S_ERD:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = S_EOUT;
            end

            S_EOUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = hit_reg ? text_char(entry_reg, pos_reg[5:0]) : rd_data;
                    out_has_next    = 1'b1;
                    out_last_next   = 1'b0;
                    out_done_next   = 1'b0;
                    out_status_next = 1'b0;
                    pos_next        = pos_reg + PW'(1);
                    if (pos_reg + PW'(1) == n_reg)
                    begin
                        count_next = CW'(SW'(count_reg) + SW'(n_reg));
                        len_next   = '0;
                        state_next = S_TAIL;
                    end
                    else
                        state_next = S_ERD;
                end
            end

            S_TAIL:
            begin
                if (end_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = '0;
                        out_has_next    = 1'b0;
                        out_last_next   = 1'b1;
                        out_done_next   = 1'b1;
                        out_status_next = ovf_reg;
                        len_next        = '0;
                        count_next      = '0;
                        ovf_next        = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else if (ovf_reg)
                    state_next = S_IDLE;
                else if (count_reg >= LIMIT_C)
                begin
                    ovf_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = byte_reg;
                    out_has_next    = 1'b1;
                    out_last_next   = 1'b1;
                    out_done_next   = 1'b0;
                    out_status_next = 1'b0;
                    count_next      = count_reg + CW'(1);
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        n_reg          <= n_next;
        byte_reg       <= byte_next;
        end_reg        <= end_next;
        hit_reg        <= hit_next;
        entry_reg      <= entry_next;
        vec_reg        <= vec_next;
        out_byte_reg   <= out_byte_next;
        out_has_reg    <= out_has_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
        out_status_reg <= out_status_next;
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.out_byte    = out_byte_reg;
    assign result_ch.has_byte    = out_has_reg;
    assign result_ch.last_of_run = out_last_reg;
    assign result_ch.done_res    = out_done_reg;
    assign result_ch.status      = out_status_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(KEEP))
        else $error("token length beyond buffer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT_C)
        else $error("output count beyond capacity");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (out_last_reg && !out_has_reg))
        else $error("status item not last or carries a byte");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text_ch.end_of_text) |=> !text_ch.ready)
        else $error("end mark did not start flush");
`endif
endmodule
